[hdl/plsl_pkg.sv]
// Package for the pinned LRU slot table: default sizes, status codes and
// sequencer types. No dependencies.
`default_nettype none

package plsl_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int KEY_BITS_DEF   = 64;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths of the ports.
  localparam int KEY_W    = 64;
  localparam int LIMIT_W  = 5;
  localparam int STATUS_W = 3;

  localparam logic [LIMIT_W-1:0] OPEN_LIMIT_RESET = 5'd16;

  // Operation codes.
  localparam logic OP_CHECKOUT = 1'b0;
  localparam logic OP_CHECKIN  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FILLED_FREE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FILLED_EVIC = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REL_IGNORED = 3'd5;
  localparam logic [STATUS_W-1:0] ST_COUNT_FULL  = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    UPD_HIT,
    UPD_EVICT,
    UPD_FILL,
    UPD_REL
  } upd_mode_e;

endpackage

`default_nettype wire

[hdl/pinned_lru_slot_table.sv]
// Pinned LRU slot table: top level with the scan/update sequencer.
// Depends on plsl_pkg and plsl_ram.
//
//  channel   handshake              payload
//  --------  ---------------------  -----------------------------------------
//  request   start / busy           opcode_i, key_i
//  result    done_o (strobe)        status_o, slot_o, pin_count_o,
//                                   evicted_count_o, evicted_key_o,
//                                   open_count_o
//  config    open_limit_we_i        open_limit_i
//
// Each transaction sweeps the slot RAM once to look up the key and then
// passes through a decision state. A hit, fill or release then sweeps
// again to rewrite ranks and pins and strobes the result. A refused
// checkout, an ignored checkin or an exhausted table skips the rewrite and
// strobes the result after the decision.
// Every eviction adds one more update and scan sweep.
// The single read port of the slot RAM is why each lookup and rewrite is a sweep.
// Reset clears the valid bits and the occupancy count at once; no clearing pass.
// busy is high from acceptance through the result strobe; the result is not
// held off by the receiver.
`default_nettype none

module pinned_lru_slot_table
  import plsl_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  open_limit_we_i,
  input  wire logic [LIMIT_W-1:0]    open_limit_i,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  opcode_i,
  input  wire logic [KEY_W-1:0]      key_i,
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [IW-1:0]              slot_o,
  output logic [COUNT_BITS-1:0]      pin_count_o,
  output logic [CW-1:0]              evicted_count_o,
  output logic [KEY_W-1:0]           evicted_key_o,
  output logic [CW-1:0]              open_count_o
);

  localparam int EW = KEY_BITS + COUNT_BITS + IW;
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  seq_state_e state_q, state_d;
  upd_mode_e  mode_q, dec_mode;

  logic [LIMIT_W-1:0]    open_limit_q;
  logic [SLOTS-1:0]      valid_q;
  logic [CW-1:0]         occ_q;
  logic                  op_q;
  logic [KEY_BITS-1:0]   key_q;

  // Sweep counter and read pipeline.
  logic [IW:0]           cnt_q;
  logic                  pend_q;
  logic [IW-1:0]         pidx_q;
  logic                  rd_en, last_beat, pass_start;

  // Lookup results gathered during a scan.
  logic                  hit_q, free_q, lru_q;
  logic [IW-1:0]         hit_idx_q, free_idx_q, lru_idx_q;
  logic [COUNT_BITS-1:0] hit_pins_q;
  logic [IW-1:0]         hit_rank_q, lru_rank_q;
  logic [KEY_BITS-1:0]   lru_key_q;

  // Update target.
  logic [IW-1:0]         tgt_q, dec_tgt;
  logic [IW-1:0]         tgt_rank_q, dec_tgt_rank;

  // Result registers.
  logic [STATUS_W-1:0]   status_q, dec_status;
  logic [IW-1:0]         slot_q, dec_slot;
  logic [COUNT_BITS-1:0] pins_q, dec_pins;
  logic [CW-1:0]         ev_cnt_q;
  logic [KEY_BITS-1:0]   ev_key_q;
  logic [CW-1:0]         open_q;
  logic                  dec_finish;

  // RAM ports.
  logic                  ram_we;
  logic [EW-1:0]         ram_wdata, ram_rdata;
  logic [KEY_BITS-1:0]   d_key;
  logic [COUNT_BITS-1:0] d_pins;
  logic [IW-1:0]         d_rank;
  logic                  d_valid;

  logic [LW-1:0]         lim;
  logic                  over_limit;

  plsl_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pidx_q),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign {d_key, d_pins, d_rank} = ram_rdata;
  assign d_valid = valid_q[pidx_q];

  // Sweep control.
  assign rd_en = ((state_q == S_SCAN) || (state_q == S_UPDATE)) &&
                 (cnt_q < (IW+1)'(SLOTS));
  assign last_beat  = pend_q && (pidx_q == LAST_IDX);
  assign pass_start = (state_d != state_q) &&
                      ((state_d == S_SCAN) || (state_d == S_UPDATE));

  // Effective limit, clamped to 1..SLOTS.
  always_comb begin
    if (open_limit_q == '0) begin
      lim = LW'(1);
    end else if (LW'(open_limit_q) > LW'(SLOTS)) begin
      lim = LW'(SLOTS);
    end else begin
      lim = LW'(open_limit_q);
    end
  end
  assign over_limit = LW'(occ_q) >= lim;

  // Decision after a scan.
  always_comb begin
    dec_finish   = 1'b1;
    dec_mode     = UPD_HIT;
    dec_tgt      = hit_idx_q;
    dec_tgt_rank = hit_rank_q;
    dec_status   = ST_EXHAUSTED;
    dec_slot     = '0;
    dec_pins     = '0;
    if (op_q == OP_CHECKOUT) begin
      if (hit_q) begin
        dec_slot = hit_idx_q;
        if (hit_pins_q == '1) begin
          dec_status = ST_COUNT_FULL;
          dec_pins   = hit_pins_q;
        end else begin
          dec_finish = 1'b0;
          dec_status = ST_HIT;
          dec_pins   = hit_pins_q + COUNT_BITS'(1);
        end
      end else if (over_limit) begin
        if (lru_q) begin
          dec_finish   = 1'b0;
          dec_mode     = UPD_EVICT;
          dec_tgt      = lru_idx_q;
          dec_tgt_rank = lru_rank_q;
        end
      end else if (free_q) begin
        dec_finish = 1'b0;
        dec_mode   = UPD_FILL;
        dec_tgt    = free_idx_q;
        dec_status = (ev_cnt_q != '0) ? ST_FILLED_EVIC : ST_FILLED_FREE;
        dec_slot   = free_idx_q;
        dec_pins   = COUNT_BITS'(1);
      end
    end else begin
      if (hit_q && (hit_pins_q != '0)) begin
        dec_finish = 1'b0;
        dec_mode   = UPD_REL;
        dec_status = ST_RELEASED;
        dec_slot   = hit_idx_q;
        dec_pins   = hit_pins_q - COUNT_BITS'(1);
      end else begin
        dec_status = ST_REL_IGNORED;
      end
    end
  end

  // Rewrite of one slot during an update sweep.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {d_key, d_pins, d_rank};
    if ((state_q == S_UPDATE) && pend_q) begin
      case (mode_q)
        UPD_HIT: begin
          if (pidx_q == tgt_q) begin
            ram_we    = 1'b1;
            ram_wdata = {d_key, d_pins + COUNT_BITS'(1), IW'(0)};
          end else if (d_valid && (d_rank < tgt_rank_q)) begin
            ram_we    = 1'b1;
            ram_wdata = {d_key, d_pins, d_rank + IW'(1)};
          end
        end
        UPD_EVICT: begin
          if (d_valid && (d_rank > tgt_rank_q)) begin
            ram_we    = 1'b1;
            ram_wdata = {d_key, d_pins, d_rank - IW'(1)};
          end
        end
        UPD_FILL: begin
          if (pidx_q == tgt_q) begin
            ram_we    = 1'b1;
            ram_wdata = {key_q, COUNT_BITS'(1), IW'(0)};
          end else if (d_valid) begin
            ram_we    = 1'b1;
            ram_wdata = {d_key, d_pins, d_rank + IW'(1)};
          end
        end
        UPD_REL: begin
          if (pidx_q == tgt_q) begin
            ram_we    = 1'b1;
            ram_wdata = {d_key, d_pins - COUNT_BITS'(1), d_rank};
          end
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (last_beat) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = dec_finish ? S_DONE : S_UPDATE;
      end
      S_UPDATE: begin
        if (last_beat) state_d = (mode_q == UPD_EVICT) ? S_SCAN : S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state: limit, valid bits, occupancy, eviction count and sweep counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_limit_q <= OPEN_LIMIT_RESET;
      valid_q      <= '0;
      occ_q        <= '0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      ev_cnt_q     <= '0;
    end else begin
      if (open_limit_we_i) open_limit_q <= open_limit_i;
      pend_q <= rd_en;
      if (pass_start) begin
        cnt_q <= '0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + (IW+1)'(1);
      end
      if ((state_q == S_IDLE) && start) ev_cnt_q <= '0;
      if (state_q == S_DECIDE && !dec_finish) begin
        if (dec_mode == UPD_EVICT) begin
          valid_q[dec_tgt] <= 1'b0;
          if (occ_q != '0) occ_q <= occ_q - CW'(1);
          ev_cnt_q <= ev_cnt_q + CW'(1);
        end else if (dec_mode == UPD_FILL) begin
          valid_q[dec_tgt] <= 1'b1;
          occ_q <= occ_q + CW'(1);
        end
      end
    end
  end

  // Datapath registers: request, scan findings, update target and result.
  always_ff @(posedge clk_i) begin
    pidx_q <= cnt_q[IW-1:0];
    if ((state_q == S_IDLE) && start) begin
      op_q     <= opcode_i;
      key_q    <= key_i[KEY_BITS-1:0];
      ev_key_q <= '0;
    end
    if (pass_start && (state_d == S_SCAN)) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      lru_q  <= 1'b0;
    end else if ((state_q == S_SCAN) && pend_q) begin
      if (d_valid && (d_key == key_q) && !hit_q) begin
        hit_q      <= 1'b1;
        hit_idx_q  <= pidx_q;
        hit_pins_q <= d_pins;
        hit_rank_q <= d_rank;
      end
      if (!d_valid && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= pidx_q;
      end
      if (d_valid && (d_pins == '0) && (!lru_q || (d_rank > lru_rank_q))) begin
        lru_q      <= 1'b1;
        lru_idx_q  <= pidx_q;
        lru_rank_q <= d_rank;
        lru_key_q  <= d_key;
      end
    end
    if (state_q == S_DECIDE) begin
      mode_q     <= dec_mode;
      tgt_q      <= dec_tgt;
      tgt_rank_q <= dec_tgt_rank;
      if ((dec_mode == UPD_EVICT) && !dec_finish) begin
        if (ev_cnt_q == '0) ev_key_q <= lru_key_q;
      end else begin
        status_q <= dec_status;
        slot_q   <= dec_slot;
        pins_q   <= dec_pins;
        open_q   <= (!dec_finish && (dec_mode == UPD_FILL)) ? occ_q + CW'(1) : occ_q;
      end
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign status_o        = status_q;
  assign slot_o          = slot_q;
  assign pin_count_o     = pins_q;
  assign evicted_count_o = ev_cnt_q;
  assign evicted_key_o   = KEY_W'(ev_key_q);
  assign open_count_o    = open_q;

`ifndef NO_ASSERTIONS
  // The occupancy count always matches the number of valid slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(occ_q))
    else $error("occupancy count differs from valid bits");

  // The result strobe lasts exactly one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // No write lands on the slot being read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && rd_en && (SLOTS > 1)) |-> (pidx_q != cnt_q[IW-1:0]))
    else $error("read and write collide on one slot");

  // A fill never pushes occupancy past the slot count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(open_count_o) <= SLOTS))
    else $error("open count beyond slot count");
`endif

endmodule

`default_nettype wire

[hdl/plsl_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module plsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[sim/pinned_lru_slot_table_tb.sv]
// Self-checking testbench for the pinned LRU slot table: a queue-fed driver, a
// result monitor and a behavioral predictor of the slot table.
// Depends on plsl_pkg and the pinned_lru_slot_table RTL.
module pinned_lru_slot_table_tb;
  import plsl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT   = 16;
  localparam int PIN_TOP = 65535;

  typedef enum {K_ITEM, K_CFG, K_DRAIN} entry_kind_e;

  typedef struct {
    entry_kind_e kind;
    logic        op;
    logic [63:0] key;
    int          gap;
    logic [4:0]  limit;
  } pending_t;

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] pins;
    logic [4:0]  ev_cnt;
    logic [63:0] ev_key;
    logic [4:0]  occ;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        open_limit_we_i;
  logic [4:0]  open_limit_i;
  logic        start;
  logic        busy;
  logic        opcode_i;
  logic [63:0] key_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic [3:0]  slot_o;
  logic [15:0] pin_count_o;
  logic [4:0]  evicted_count_o;
  logic [63:0] evicted_key_o;
  logic [4:0]  open_count_o;

  pending_t pending_q[$];
  outcome_t outcome_q[$];
  int       err_cnt = 0;

  // Predicted table contents.
  bit          tv[NSLOT];
  logic [63:0] tkey[NSLOT];
  int          tpins[NSLOT];
  int          trank[NSLOT];
  int          tocc = 0;
  logic [4:0]  tlimit = OPEN_LIMIT_RESET;

  pinned_lru_slot_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .open_limit_we_i(open_limit_we_i), .open_limit_i(open_limit_i),
    .start(start), .busy(busy), .opcode_i(opcode_i), .key_i(key_i),
    .done_o(done_o), .status_o(status_o), .slot_o(slot_o),
    .pin_count_o(pin_count_o), .evicted_count_o(evicted_count_o),
    .evicted_key_o(evicted_key_o), .open_count_o(open_count_o)
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // Computes the outcome of one transaction and updates the predicted table.
  function automatic outcome_t table_lookup_update(input logic op, input logic [63:0] k);
    outcome_t r;
    int s, best, i, lim;
    bit stuck;
    r = '{default: '0};
    s = -1;
    for (i = 0; i < NSLOT; i++)
      if (s < 0 && tv[i] && tkey[i] == k) s = i;
    if (op == OP_CHECKOUT) begin
      if (s >= 0) begin
        if (tpins[s] >= PIN_TOP) begin
          r.status = ST_COUNT_FULL;
        end else begin
          tpins[s]++;
          for (i = 0; i < NSLOT; i++)
            if (tv[i] && i != s && trank[i] < trank[s]) trank[i]++;
          trank[s] = 0;
          r.status = ST_HIT;
        end
        r.slot = s;
        r.pins = tpins[s];
      end else begin
        lim = tlimit;
        if (lim < 1) lim = 1;
        if (lim > NSLOT) lim = NSLOT;
        stuck = 0;
        // Evict least recent unpinned slots until below the limit.
        while (!stuck && tocc >= lim) begin
          best = -1;
          for (i = 0; i < NSLOT; i++)
            if (tv[i] && tpins[i] == 0 && (best < 0 || trank[i] > trank[best])) best = i;
          if (best < 0) begin
            stuck = 1;
          end else begin
            for (i = 0; i < NSLOT; i++)
              if (tv[i] && trank[i] > trank[best]) trank[i]--;
            tv[best] = 0;
            tocc--;
            if (r.ev_cnt == 0) r.ev_key = tkey[best];
            r.ev_cnt++;
          end
        end
        s = -1;
        if (!stuck)
          for (i = 0; i < NSLOT; i++)
            if (s < 0 && !tv[i]) s = i;
        if (s < 0) begin
          r.status = ST_EXHAUSTED;
        end else begin
          for (i = 0; i < NSLOT; i++)
            if (tv[i]) trank[i]++;
          tv[s] = 1;
          tkey[s] = k;
          tpins[s] = 1;
          trank[s] = 0;
          tocc++;
          r.status = (r.ev_cnt != 0) ? ST_FILLED_EVIC : ST_FILLED_FREE;
          r.slot = s;
          r.pins = 1;
        end
      end
    end else begin
      if (s >= 0 && tpins[s] > 0) begin
        tpins[s]--;
        r.status = ST_RELEASED;
        r.slot = s;
        r.pins = tpins[s];
      end else begin
        r.status = ST_REL_IGNORED;
      end
    end
    r.occ = tocc;
    return r;
  endfunction

  // Driver: feeds transactions, register writes and drain pauses from the queue.
  pending_t cur;
  bit       armed = 0;
  int       hold = 0;
  int       settle = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic nstart, nwe;
    if (!rst_ni) begin
      start <= 1'b0;
      open_limit_we_i <= 1'b0;
    end else begin
      nstart = start;
      nwe = 1'b0;
      if (!busy && !done_o && outcome_q.size() == 0) settle++;
      else settle = 0;
      if (start && !busy) begin
        outcome_q.push_back(table_lookup_update(opcode_i, key_i));
        nstart = 1'b0;
      end else if (!start) begin
        if (hold > 0) begin
          if (!busy && !done_o) hold--;
        end else if (armed) begin
          opcode_i <= cur.op;
          key_i <= cur.key;
          nstart = 1'b1;
          armed = 0;
        end else if (pending_q.size() > 0) begin
          case (pending_q[0].kind)
            K_ITEM: begin
              cur = pending_q.pop_front();
              hold = cur.gap;
              armed = 1;
            end
            K_CFG: begin
              if (settle >= 4) begin
                open_limit_i <= pending_q[0].limit;
                tlimit = pending_q[0].limit;
                nwe = 1'b1;
                void'(pending_q.pop_front());
              end
            end
            default: begin
              if (settle >= 1) void'(pending_q.pop_front());
            end
          endcase
        end
      end
      start <= nstart;
      open_limit_we_i <= nwe;
    end
  end

  // Monitor: compares each result strobe with the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("Unexpected result: status %0d slot %0d", status_o, slot_o);
      end else begin
        e = outcome_q.pop_front();
        if (status_o !== e.status || slot_o !== e.slot || pin_count_o !== e.pins ||
            evicted_count_o !== e.ev_cnt || evicted_key_o !== e.ev_key ||
            open_count_o !== e.occ) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("Mismatch expected: st %0d slot %0d pins %0d evc %0d evk %h occ %0d",
                     e.status, e.slot, e.pins, e.ev_cnt, e.ev_key, e.occ);
            $display("         actual:   st %0d slot %0d pins %0d evc %0d evk %h occ %0d",
                     status_o, slot_o, pin_count_o, evicted_count_o, evicted_key_o,
                     open_count_o);
          end
        end
      end
    end
  end

  task automatic add_item(input logic op, input logic [63:0] k, input int gap);
    pending_t p;
    p = '{kind: K_ITEM, op: op, key: k, gap: gap, limit: '0};
    pending_q.push_back(p);
  endtask

  task automatic add_limit(input logic [4:0] v);
    pending_t p;
    p = '{kind: K_DRAIN, op: 1'b0, key: '0, gap: 0, limit: '0};
    pending_q.push_back(p);
    p.kind = K_CFG;
    p.limit = v;
    pending_q.push_back(p);
  endtask

  // Stimulus and end of run.
  initial begin
    logic [63:0] pool[20];
    logic [4:0]  limits[8];
    logic [63:0] k;
    logic        op;
    int          i, n, g;
    for (i = 0; i < NSLOT; i++) begin
      tv[i] = 0; tkey[i] = '0; tpins[i] = 0; trank[i] = 0;
    end
    rst_ni = 1'b0;
    start = 1'b0;
    open_limit_we_i = 1'b0;
    open_limit_i = '0;
    opcode_i = OP_CHECKOUT;
    key_i = '0;

    // Directed: key extremes, hits, releases and ignored releases.
    add_limit(5'd16);
    add_item(OP_CHECKOUT, 64'd0, 0);
    add_item(OP_CHECKOUT, '1, 1);
    add_item(OP_CHECKOUT, '1, 0);
    add_item(OP_CHECKIN, '1, 2);
    add_item(OP_CHECKIN, '1, 0);
    add_item(OP_CHECKIN, '1, 0);
    add_item(OP_CHECKIN, 64'h123, 3);
    add_item(OP_CHECKIN, 64'd0, 0);
    for (i = 1; i <= 6; i++) add_item(OP_CHECKOUT, 64'hA5A5_0000_0000_0000 + i, 0);
    add_item(OP_CHECKIN, 64'hA5A5_0000_0000_0003, 0);
    add_item(OP_CHECKIN, 64'hA5A5_0000_0000_0004, 0);
    // Lowered limit: several evictions, then exhausted with evictions done.
    add_limit(5'd3);
    add_item(OP_CHECKOUT, 64'h5A5A_5A5A_5A5A_5A5A, 0);
    add_item(OP_CHECKIN, 64'hA5A5_0000_0000_0001, 0);
    add_item(OP_CHECKOUT, 64'h5A5A_5A5A_5A5A_5A5A, 0);
    // Out-of-range limits act as one and as the slot count.
    add_limit(5'd0);
    add_item(OP_CHECKOUT, 64'h0F0F_0F0F_0F0F_0F0F, 0);
    add_limit(5'd31);
    add_item(OP_CHECKOUT, 64'hF0F0_F0F0_F0F0_F0F0, 0);
    // Checkout and checkin of one more key at the full limit.
    add_limit(5'd16);
    add_item(OP_CHECKOUT, 64'hC0DE_0000_FFFF_0001, 0);
    add_item(OP_CHECKIN, 64'hC0DE_0000_FFFF_0001, 0);

    // Random phases over a pool of keys, with an occasional wild key.
    for (i = 0; i < 20; i++) pool[i] = {$urandom, $urandom};
    limits = '{5'd31, 5'd1, 5'd8, 5'd17, 5'd5, 5'd0, 5'd12, 5'd16};
    for (n = 0; n < 8; n++) begin
      add_limit((n == 7) ? 5'($urandom_range(0, 31)) : limits[n]);
      for (i = 0; i < 85; i++) begin
        if ($urandom_range(0, 99) < 8) k = {$urandom, $urandom};
        else k = pool[$urandom_range(0, 19)];
        op = ($urandom_range(0, 99) < 55) ? OP_CHECKOUT : OP_CHECKIN;
        g = (n == 3) ? 0 : $urandom_range(0, 6);
        add_item(op, k, g);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || armed || start || outcome_q.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    err_cnt += outcome_q.size();
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog.
  initial begin
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
